// ===== hw/rtl/rmst_pkg.sv =====
// rmst_pkg: shared types and constants for the range maximum segment tree.
// No dependencies; used by every module of the block but rmst_ram.

package rmst_pkg;

    localparam int VALUE_BITS = 32;
    localparam int INDEX_W    = 10;
    localparam int SIZE_W     = 11;
    localparam int TDATA_W    = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // offset binary: sign bit flipped so an unsigned compare orders signed values
    localparam logic [VALUE_BITS-1:0] SIGN_MASK = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // input word layout, lowest bit first
    localparam int IDX_LSB = 0;
    localparam int VAL_LSB = IDX_LSB + INDEX_W;
    localparam int LO_LSB  = VAL_LSB + VALUE_BITS;
    localparam int HI_LSB  = LO_LSB + INDEX_W;

    // operation codes carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register index as seen on paddr[2]
    localparam logic REG_SIZE_IN_USE = 1'b0;

    typedef struct packed {
        logic                  op;
        logic [INDEX_W-1:0]    idx;
        logic [VALUE_BITS-1:0] value;
        logic [INDEX_W-1:0]    lo;
        logic [INDEX_W-1:0]    hi;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] maximum;
        logic                  empty;
    } res_t;

endpackage

// ===== hw/rtl/rmst_ram.sv =====
// rmst_ram: generic single write port, single read port RAM, registered read.
// No dependencies.

module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== hw/rtl/rmst_seq.sv =====
// rmst_seq: sequencer that walks the tree, with the shared max unit and node RAM.
// Depends on rmst_pkg and rmst_ram.

module rmst_seq #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [((($clog2(2*MAX_ELEMENTS)+1) > rmst_pkg::SIZE_W) ?
                   ($clog2(2*MAX_ELEMENTS)+1) : rmst_pkg::SIZE_W)-1:0] size_eff,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  rmst_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output rmst_pkg::res_t res
);

    localparam int DEPTH = 2 * MAX_ELEMENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = ((AW + 1) > rmst_pkg::SIZE_W) ? (AW + 1) : rmst_pkg::SIZE_W;
    localparam int VB    = rmst_pkg::VALUE_BITS;

    localparam logic [CW-1:0] LEAF_BASE = CW'(MAX_ELEMENTS);
    localparam logic [CW-1:0] ONE       = CW'(1);
    localparam logic [AW-1:0] LAST_NODE = AW'(DEPTH - 1);

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_W_LEAF = 9'b000000100,
        ST_W_UPD  = 9'b000001000,
        ST_Q_TEST = 9'b000010000,
        ST_Q_LMAX = 9'b000100000,
        ST_Q_RMAX = 9'b001000000,
        ST_DONE   = 9'b010000000,
        ST_SPARE  = 9'b100000000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  pos_reg, pos_next;     // leaf/ancestor on writes, left edge on queries
    logic [CW-1:0]  rpos_reg, rpos_next;   // right edge (exclusive) on queries
    logic [VB-1:0]  acc_reg, acc_next;     // running key
    logic           empty_reg, empty_next;
    logic [AW-1:0]  clr_reg, clr_next;

    logic [CW-1:0]  idx_ext, lo_ext, hi_ext, size_m1, hi_clip;
    logic           q_empty, w_ok;
    logic [CW-1:0]  parent, sib, parent_sib, rpos_m1, pos_p1;
    logic [VB-1:0]  key_in, max_out;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [VB-1:0]  wdata, rdata;

    rmst_ram #(
        .WIDTH (VB),
        .DEPTH (DEPTH)
    ) u_nodes (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign key_in  = cmd.value ^ rmst_pkg::SIGN_MASK;
    assign idx_ext = CW'(cmd.idx);
    assign lo_ext  = CW'(cmd.lo);
    assign hi_ext  = CW'(cmd.hi);
    assign size_m1 = size_eff - ONE;
    assign hi_clip = (hi_ext > size_m1) ? size_m1 : hi_ext;
    assign q_empty = (size_eff == '0) || (lo_ext > hi_clip);
    assign w_ok    = idx_ext < size_eff;

    assign parent     = pos_reg >> 1;
    assign sib        = pos_reg ^ ONE;
    assign parent_sib = parent ^ ONE;
    assign rpos_m1    = rpos_reg - ONE;
    assign pos_p1     = pos_reg + ONE;

    // shared max unit on offset-binary keys
    assign max_out = (rdata > acc_reg) ? rdata : acc_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        rpos_next  = rpos_reg;
        acc_next   = acc_reg;
        empty_next = empty_reg;
        clr_next   = clr_reg;
        we         = 1'b0;
        waddr      = pos_reg[AW-1:0];
        wdata      = acc_reg;
        raddr      = pos_reg[AW-1:0];
        cmd_ready  = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_NODE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd.op == rmst_pkg::OP_QUERY)
                    begin
                        acc_next   = '0;
                        empty_next = q_empty;
                        pos_next   = lo_ext + LEAF_BASE;
                        rpos_next  = hi_clip + LEAF_BASE + ONE;
                        state_next = q_empty ? ST_DONE : ST_Q_TEST;
                    end
                    else if (w_ok)
                    begin
                        pos_next   = idx_ext + LEAF_BASE;
                        acc_next   = key_in;
                        state_next = ST_W_LEAF;
                    end
                end
            end
            ST_W_LEAF:
            begin
                we         = 1'b1;
                raddr      = sib[AW-1:0];
                state_next = ST_W_UPD;
            end
            ST_W_UPD:
            begin
                we       = 1'b1;
                waddr    = parent[AW-1:0];
                wdata    = max_out;
                acc_next = max_out;
                pos_next = parent;
                raddr    = parent_sib[AW-1:0];
                if (parent == ONE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_Q_TEST:
            begin
                if (pos_reg >= rpos_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (pos_reg[0])
                begin
                    state_next = ST_Q_LMAX;
                end
                else if (rpos_reg[0])
                begin
                    raddr      = rpos_m1[AW-1:0];
                    state_next = ST_Q_RMAX;
                end
                else
                begin
                    pos_next  = pos_reg >> 1;
                    rpos_next = rpos_reg >> 1;
                end
            end
            ST_Q_LMAX:
            begin
                acc_next = max_out;
                if (rpos_reg[0])
                begin
                    raddr      = rpos_m1[AW-1:0];
                    pos_next   = pos_p1;
                    state_next = ST_Q_RMAX;
                end
                else
                begin
                    pos_next   = pos_p1 >> 1;
                    rpos_next  = rpos_reg >> 1;
                    state_next = ST_Q_TEST;
                end
            end
            ST_Q_RMAX:
            begin
                acc_next   = max_out;
                pos_next   = pos_reg >> 1;
                rpos_next  = rpos_m1 >> 1;
                state_next = ST_Q_TEST;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        rpos_reg  <= rpos_next;
        acc_reg   <= acc_next;
        empty_reg <= empty_next;
    end

    assign res.maximum = acc_reg ^ rmst_pkg::SIGN_MASK;
    assign res.empty   = empty_reg;

endmodule

// ===== hw/rtl/range_max_segment_tree.sv =====
// range_max_segment_tree: top level, stream ports, size register, result register.
// Depends on rmst_pkg and rmst_seq (which holds rmst_ram).
//
// Usage
//   Input words arrive on s_axis_*. tuser selects the operation: a write
//   stores one signed element and gives no result; a query returns the
//   maximum over [query_low, query_high] on m_axis_*, with tuser set when
//   the clipped range is empty (tdata then holds the most negative value).
//   size_in_use sits on the APB port at byte address 0; write it only while
//   the block is idle. High ends are clipped to the size, writes beyond it
//   are dropped.
// Sequence (L = ceil(log2(2*MAX_ELEMENTS)) - 1 tree levels above the leaves)
//   Write: accept, leaf write, then one parent update per level up to the root.
//   Query: accept, then per level a test and up to a left and a right
//   read-max step, then hand over to the output register. Both are bound by
//   the one read port of the node RAM feeding the single max comparator.
// Reset
//   All 2*MAX_ELEMENTS nodes are swept to the most negative value, one per
//   cycle; s_axis_tready stays low meanwhile, APB writes are still taken.
// Back-pressure
//   A result waits in the output register; the next word is accepted
//   meanwhile. If a second result is ready before the first is taken, the
//   sequencer holds it and stops accepting words.

module range_max_segment_tree #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_axis_tdata: element_index[9:0], element_value[41:10],
    //               query_low[51:42], query_high[61:52], zero pad[63:62]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rmst_pkg::TDATA_W-1:0]    s_axis_tdata,
    input  logic [0:0]                      s_axis_tuser,   // operation[0]
    // m_axis_tdata: range_maximum[31:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rmst_pkg::VALUE_BITS-1:0] m_axis_tdata,
    output logic [0:0]                      m_axis_tuser,   // empty_range[0]
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int AW = $clog2(2 * MAX_ELEMENTS);
    localparam int CW = ((AW + 1) > rmst_pkg::SIZE_W) ? (AW + 1) : rmst_pkg::SIZE_W;

    logic [rmst_pkg::SIZE_W-1:0] size_reg;
    logic [CW-1:0]               size_ext, size_eff;
    logic                        cfg_wr;

    rmst_pkg::cmd_t cmd;
    rmst_pkg::res_t res;
    rmst_pkg::res_t out_data_reg;
    logic           res_valid, res_ready;
    logic           out_valid_reg;

    // APB: no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == rmst_pkg::REG_SIZE_IN_USE);

    always_comb
    begin
        unique case (paddr[2])
            rmst_pkg::REG_SIZE_IN_USE: prdata = 32'(size_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= rmst_pkg::SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            size_reg <= pwdata[rmst_pkg::SIZE_W-1:0];
        end
    end

    // sizes above the tree capacity act as the capacity
    assign size_ext = CW'(size_reg);
    assign size_eff = (size_ext > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : size_ext;

    // unpack the input word
    assign cmd.op    = s_axis_tuser[0];
    assign cmd.idx   = s_axis_tdata[rmst_pkg::IDX_LSB +: rmst_pkg::INDEX_W];
    assign cmd.value = s_axis_tdata[rmst_pkg::VAL_LSB +: rmst_pkg::VALUE_BITS];
    assign cmd.lo    = s_axis_tdata[rmst_pkg::LO_LSB  +: rmst_pkg::INDEX_W];
    assign cmd.hi    = s_axis_tdata[rmst_pkg::HI_LSB  +: rmst_pkg::INDEX_W];

    rmst_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .size_eff  (size_eff),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: free or being emptied this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg.maximum;
    assign m_axis_tuser[0] = out_data_reg.empty;

endmodule

// ===== hw/rtl/rmst_checker.sv =====
// rmst_checker: port-level assertions for range_max_segment_tree, with its bind.
// Depends on rmst_pkg; attached to the top level by the bind below.

module rmst_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [0:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rmst_pkg::VALUE_BITS-1:0] m_axis_tdata,
    input logic [0:0]                      m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // empty range reports the most negative value
    a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == rmst_pkg::SIGN_MASK)
        else $error("empty range without most negative value");

    // node clearing keeps input closed straight after reset
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_axis_tready)
        else $error("input open during node clearing");

    // a query always occupies the sequencer
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
        else $error("input open right after a query");

    // a write never produces a result word
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> !$rose(m_axis_tvalid))
        else $error("result word after a write");

endmodule

bind range_max_segment_tree rmst_checker u_rmst_checker (.*);

// ===== sim/tb_range_max_segment_tree.sv =====
// tb_range_max_segment_tree: self-checking bench for the range maximum segment tree.
// Depends on rmst_pkg and range_max_segment_tree; directed table then random
// phases over several sizes, checked against a leaf-array predictor.

module tb_range_max_segment_tree;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int ELEMENTS = 1024;
    localparam logic [rmst_pkg::VALUE_BITS-1:0] MOST_NEGATIVE = rmst_pkg::SIGN_MASK;
    localparam logic [rmst_pkg::VALUE_BITS-1:0] MOST_POSITIVE = ~rmst_pkg::SIGN_MASK;
    // Margin so a write still walking the tree ends before APB is touched.
    localparam int DRAIN_CYCLES = 80;
    // Cycles without any word moving on either side; set well above the reset sweep.
    localparam int STALL_LIMIT  = 20000;
    localparam int MAX_GAP      = 40;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [rmst_pkg::TDATA_W-1:0]    s_axis_tdata;  // idx[9:0] value[41:10] lo[51:42] hi[61:52]
    logic [0:0]                      s_axis_tuser;  // operation[0]
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [rmst_pkg::VALUE_BITS-1:0] m_axis_tdata;  // range_maximum[31:0]
    logic [0:0]                      m_axis_tuser;  // empty_range[0]
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [2:0]                      paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    range_max_segment_tree i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: plain leaf array plus the size register. A range
    // maximum over the leaves is what the tree must reproduce, so there is
    // no need to model inner nodes.
    // ------------------------------------------------------------------
    logic signed [rmst_pkg::VALUE_BITS-1:0] leaf_value [0:ELEMENTS-1];
    logic [rmst_pkg::SIZE_W-1:0]            size_shadow;

    rmst_pkg::res_t answers_due [$];    // expected results, oldest first

    int error_count;
    int stall_cycles;
    int sender_idle_pct;
    int receiver_stall_pct;
    int writes_sent;
    int queries_sent;
    int empties_sent;
    int settings_used;

    // directed table row; typed rows carry a hand-written answer
    typedef struct {
        logic                            op;
        logic [rmst_pkg::INDEX_W-1:0]    idx;
        logic [rmst_pkg::VALUE_BITS-1:0] value;
        logic [rmst_pkg::INDEX_W-1:0]    lo;
        logic [rmst_pkg::INDEX_W-1:0]    hi;
        bit                              typed;
        logic [rmst_pkg::VALUE_BITS-1:0] want_max;
        logic                            want_empty;
    } tree_row_t;

    tree_row_t directed_rows [$];

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor: applies one accepted word, returns 1 with the answer when
    // the word is a query.
    // ------------------------------------------------------------------
    function automatic int unsigned covered_elements();
        return (size_shadow > rmst_pkg::SIZE_W'(ELEMENTS)) ? ELEMENTS : int'(size_shadow);
    endfunction

    function automatic bit tree_predict(input logic op,
                                        input logic [rmst_pkg::TDATA_W-1:0] word,
                                        output rmst_pkg::res_t answer);
        int unsigned                            covered;
        int unsigned                            idx;
        int unsigned                            lo;
        int unsigned                            hi;
        logic signed [rmst_pkg::VALUE_BITS-1:0] best;
        covered = covered_elements();
        idx     = 32'(word[rmst_pkg::IDX_LSB +: rmst_pkg::INDEX_W]);
        lo      = 32'(word[rmst_pkg::LO_LSB +: rmst_pkg::INDEX_W]);
        hi      = 32'(word[rmst_pkg::HI_LSB +: rmst_pkg::INDEX_W]);
        answer  = '0;
        if (op == rmst_pkg::OP_WRITE) begin
            // writes at or past the size in use are dropped
            if (idx < covered)
                leaf_value[idx] = word[rmst_pkg::VAL_LSB +: rmst_pkg::VALUE_BITS];
            return 1'b0;
        end
        best = MOST_NEGATIVE;
        if (covered == 0) begin
            answer.empty = 1'b1;
        end
        else begin
            if (hi > covered - 1)
                hi = covered - 1;
            answer.empty = (lo > hi);
        end
        if (!answer.empty) begin
            for (int unsigned i = lo; i <= hi; i++)
                if (leaf_value[i] > best)
                    best = leaf_value[i];
        end
        answer.maximum = best;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [rmst_pkg::TDATA_W-1:0] pack_word(
            input logic [rmst_pkg::INDEX_W-1:0]    idx,
            input logic [rmst_pkg::VALUE_BITS-1:0] value,
            input logic [rmst_pkg::INDEX_W-1:0]    lo,
            input logic [rmst_pkg::INDEX_W-1:0]    hi,
            input logic [1:0]                      pad);
        logic [rmst_pkg::TDATA_W-1:0] word;
        word = '0;
        word[rmst_pkg::IDX_LSB +: rmst_pkg::INDEX_W]    = idx;
        word[rmst_pkg::VAL_LSB +: rmst_pkg::VALUE_BITS] = value;
        word[rmst_pkg::LO_LSB +: rmst_pkg::INDEX_W]     = lo;
        word[rmst_pkg::HI_LSB +: rmst_pkg::INDEX_W]     = hi;
        word[rmst_pkg::TDATA_W-1 -: 2]                  = pad;
        return word;
    endfunction

    // Called at a rising edge; returns at the edge that accepted the word.
    // tvalid is only lowered when a gap is actually taken, so a back-to-back
    // word never sees two assignments in one step.
    task automatic send_word(input logic op, input logic [rmst_pkg::TDATA_W-1:0] word,
                             input bit typed, input rmst_pkg::res_t typed_answer);
        int             gap;
        rmst_pkg::res_t answer;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        if (tree_predict(op, word, answer))
        begin
            if (typed)
                answer = typed_answer;
            answers_due.push_back(answer);
            queries_sent++;
            if (answer.empty)
                empties_sent++;
        end
        else
        begin
            writes_sent++;
        end
    endtask

    // tvalid is already low here; let every expected result arrive, then let
    // any write still walking the tree finish before the register may change.
    task automatic settle_block();
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write of size_in_use: setup cycle, access cycle, done on pready.
    // Upper pwdata bits carry junk to show they are ignored.
    task automatic write_size(input logic [rmst_pkg::SIZE_W-1:0] size);
        logic [31:0] bus_word;
        bus_word                       = $urandom();
        bus_word[rmst_pkg::SIZE_W-1:0] = size;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {rmst_pkg::REG_SIZE_IN_USE, 2'b00};
        pwdata  <= bus_word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_shadow = size;
        settings_used++;
    endtask

    function automatic logic [rmst_pkg::VALUE_BITS-1:0] pick_value();
        case ($urandom_range(7))
            0:       return MOST_POSITIVE;
            1:       return MOST_NEGATIVE;
            2:       return rmst_pkg::VALUE_BITS'(int'($urandom_range(6)) - 3); // ties near zero
            3:       return MOST_NEGATIVE + rmst_pkg::VALUE_BITS'($urandom_range(3));
            default: return $urandom();
        endcase
    endfunction

    // Mostly inside the size in use, sometimes anywhere in the field.
    function automatic logic [rmst_pkg::INDEX_W-1:0] pick_index(input int unsigned covered);
        if (covered > 0 && $urandom_range(9) < 7)
            return rmst_pkg::INDEX_W'($urandom_range(covered - 1));
        return rmst_pkg::INDEX_W'($urandom_range(ELEMENTS - 1));
    endfunction

    task automatic send_random_word();
        logic                         op;
        logic [rmst_pkg::INDEX_W-1:0] lo;
        logic [rmst_pkg::INDEX_W-1:0] hi;
        logic [rmst_pkg::INDEX_W-1:0] swap;
        int unsigned                  covered;
        covered = covered_elements();
        op      = $urandom_range(1) ? rmst_pkg::OP_QUERY : rmst_pkg::OP_WRITE;
        lo      = pick_index(covered);
        hi      = pick_index(covered);
        // ordered ranges most of the time; the rest stay reversed or clipped
        if (lo > hi && $urandom_range(9) < 8)
        begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        if ($urandom_range(19) == 0)
            hi = rmst_pkg::INDEX_W'(ELEMENTS - 1);
        send_word(op, pack_word(pick_index(covered), pick_value(), lo, hi,
                                2'($urandom_range(3))), 1'b0, '0);
    endtask

    // One setting of the register, one idling pattern, a batch of words.
    // Halfway through the sender holds off until the block has drained.
    task automatic run_phase(input logic [rmst_pkg::SIZE_W-1:0] size, input int idle_pct,
                             input int stall_pct, input int words);
        settle_block();
        write_size(size);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < words; n++)
        begin
            if (n == words / 2)
            begin
                s_axis_tvalid <= 1'b0;
                do @(posedge clk); while (answers_due.size() != 0);
            end
            send_random_word();
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic add_row(input logic op, input logic [rmst_pkg::INDEX_W-1:0] idx,
                           input logic [rmst_pkg::VALUE_BITS-1:0] value,
                           input logic [rmst_pkg::INDEX_W-1:0] lo,
                           input logic [rmst_pkg::INDEX_W-1:0] hi,
                           input bit typed, input logic [rmst_pkg::VALUE_BITS-1:0] want_max,
                           input logic want_empty);
        tree_row_t row;
        row.op         = op;
        row.idx        = idx;
        row.value      = value;
        row.lo         = lo;
        row.hi         = hi;
        row.typed      = typed;
        row.want_max   = want_max;
        row.want_empty = want_empty;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order comparison.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rmst_pkg::res_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (answers_due.size() == 0)
            begin
                report_mismatch("unexpected result word", m_axis_tdata, '0);
            end
            else
            begin
                due = answers_due.pop_front();
                if (m_axis_tdata !== due.maximum)
                    report_mismatch("range_maximum", m_axis_tdata, due.maximum);
                if (m_axis_tuser[0] !== due.empty)
                    report_mismatch("empty_range", 32'(m_axis_tuser), 32'(due.empty));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: counts cycles in which no word moves on either stream.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rmst_pkg::res_t typed_answer;
        tree_row_t      row;

        // every input known from time zero
        rst_n              = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        s_axis_tuser       = rmst_pkg::OP_WRITE;
        m_axis_tready      = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        error_count        = 0;
        stall_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        writes_sent        = 0;
        queries_sent       = 0;
        empties_sent       = 0;
        settings_used      = 0;
        size_shadow        = rmst_pkg::SIZE_RESET;
        for (int i = 0; i < ELEMENTS; i++)
            leaf_value[i] = MOST_NEGATIVE;

        // Directed table at the reset size. Typed answers are the ones that
        // follow from reset contents, extremes and empty ranges.
        //  op                  idx      value          lo       hi    typed want  empty
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd0, 10'd1023, 1, MOST_NEGATIVE, 1'b0);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd5, 10'd3, 1, MOST_NEGATIVE, 1'b1);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd1023, 10'd1023, 1, MOST_NEGATIVE, 1'b0);
        add_row(rmst_pkg::OP_WRITE, 10'd0, MOST_POSITIVE, 10'd0, 10'd0, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_WRITE, 10'd1023, MOST_NEGATIVE, 10'd0, 10'd0, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_WRITE, 10'd512, 32'hFFFF_FFFF, 10'd0, 10'd0, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd0, 10'd1023, 1, MOST_POSITIVE, 1'b0);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd1, 10'd1023, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd1023, 10'd1023, 1, MOST_NEGATIVE, 1'b0);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd513, 10'd1022, 1, MOST_NEGATIVE, 1'b0);
        // unused query fields all ones on a write, and the reverse
        add_row(rmst_pkg::OP_WRITE, 10'd0, 32'h0, 10'd1023, 10'd1023, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd0, 10'd0, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_WRITE, 10'd1023, 32'h1, 10'd1023, 10'd0, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_QUERY, 10'd1023, 32'hFFFF_FFFF, 10'd0, 10'd1023, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd1023, 10'd0, 1, MOST_NEGATIVE, 1'b1);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd1023, 10'd1023, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_WRITE, 10'd300, 32'h8000_0001, 10'd0, 10'd0, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_WRITE, 10'd301, 32'h5555_5555, 10'd0, 10'd0, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_WRITE, 10'd302, 32'hAAAA_AAAA, 10'd0, 10'd0, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd300, 10'd302, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd300, 10'd300, 0, '0, 1'b0);
        add_row(rmst_pkg::OP_QUERY, 10'd0, 32'h0, 10'd0, 10'd1023, 0, '0, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // s_axis_tready is held low through the node sweep; send_word simply
        // waits for it.
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            typed_answer.maximum = row.want_max;
            typed_answer.empty   = row.want_empty;
            send_word(row.op, pack_word(row.idx, row.value, row.lo, row.hi, 2'b00),
                      row.typed, typed_answer);
        end
        s_axis_tvalid <= 1'b0;

        // Random phases. Sizes run through the full size, sixteen, one element,
        // zero, above capacity (stored leaves reappear), two, a random value and
        // the full size again, each with a set idling pattern.
        run_phase(11'd1024, 0,  0,  300);
        run_phase(11'd16,   72, 0,  250);
        run_phase(11'd1,    0,  72, 150);
        run_phase(11'd0,    33, 33, 80);
        run_phase(11'd2047, 33, 33, 300);
        run_phase(11'd2,    72, 0,  150);
        run_phase(rmst_pkg::SIZE_W'($urandom_range(1023, 3)), 0, 72, 250);
        run_phase(11'd1024, 0,  0,  220);

        // drain; the watchdog covers a result that never arrives
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d writes and %0d queries (%0d empty) over %0d size settings",
                 writes_sent, queries_sent, empties_sent, settings_used);
        $display("with sender gaps and result back-pressure; %0d mismatches", error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
